/* design/assert_macros.svh */
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

/* design/rrd_pkg.sv */
`timescale 1ns / 1ps
package rrd_pkg;

    localparam int ADDR_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes, selected by paddr[2].
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_COLUMN_TYPES = 1'b1;

    // Column type codes; the remaining codes are decoded as BOOL.
    localparam logic [1:0] TYPE_INT     = 2'd0;
    localparam logic [1:0] TYPE_VARCHAR = 2'd1;

    // Result kinds.
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;
    localparam logic [1:0] KIND_LEN  = 2'd2;
    localparam logic [1:0] KIND_CHAR = 2'd3;

    typedef enum logic [1:0] {
        PH_BITMAP = 2'd0,
        PH_FIELD  = 2'd1,
        PH_CHARS  = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [4:0]  column_count;
        logic [31:0] column_types;
    } rrd_cfg_t;

    typedef struct packed {
        logic [3:0]  column_index;
        logic [1:0]  kind;
        logic        is_null;
        logic [31:0] value;
        logic        last_of_row;
    } rrd_item_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] column;
    } rrd_parse_status_t;

    typedef struct packed {
        logic [1:0] count;
    } rrd_queue_status_t;

endpackage

/* design/rrd_cfg.sv */
`timescale 1ns / 1ps
module rrd_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rrd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rrd_pkg::rrd_cfg_t          cfg
);
    import rrd_pkg::*;

    logic [4:0]  column_count_reg;
    logic [31:0] column_types_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= 5'd1;
            column_types_reg <= 32'd0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_COLUMN_COUNT: column_count_reg <= pwdata[4:0];
                REG_COLUMN_TYPES: column_types_reg <= pwdata;
                default:          column_count_reg <= column_count_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_COLUMN_COUNT: prdata = {27'd0, column_count_reg};
            REG_COLUMN_TYPES: prdata = column_types_reg;
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.column_count = column_count_reg;
    assign cfg.column_types = column_types_reg;

endmodule

/* design/rrd_parser.sv */
`timescale 1ns / 1ps
module rrd_parser #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rrd_pkg::rrd_cfg_t          cfg,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       row_start,
    output logic                       push,
    output rrd_pkg::rrd_item_t         item,
    output rrd_pkg::rrd_parse_status_t status
);
    import rrd_pkg::*;

    localparam int EFF_MAX = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;

    phase_t      phase_reg, phase_next;
    logic [15:0] null_bits_reg, null_bits_next;
    logic        bm_idx_reg, bm_idx_next;
    logic [3:0]  column_reg, column_next;
    logic [1:0]  fbc_reg, fbc_next;
    logic [31:0] value_reg, value_next;
    logic [15:0] chars_reg, chars_next;

    phase_t      ph;
    logic        bm_idx;
    logic [4:0]  eff_cols;
    logic        is_null;
    logic [1:0]  col_type;
    logic [31:0] int_value;
    logic [15:0] len;
    logic [15:0] chars_dec;
    logic        last;
    logic        do_end;
    logic        do_mid;

    always_comb begin
        if (cfg.column_count == 5'd0) begin
            eff_cols = 5'd1;
        end else if (cfg.column_count > 5'(EFF_MAX)) begin
            eff_cols = 5'(EFF_MAX);
        end else begin
            eff_cols = cfg.column_count;
        end
    end

    // A row start drops whatever partial row is in progress.
    assign ph     = row_start ? PH_BITMAP : phase_reg;
    assign bm_idx = row_start ? 1'b0 : bm_idx_reg;

    assign is_null   = null_bits_reg[column_reg];
    assign col_type  = cfg.column_types[{column_reg, 1'b0} +: 2];
    assign int_value = value_reg | ({24'd0, data_byte} << {fbc_reg, 3'b000});
    assign len       = {data_byte, value_reg[7:0]};
    assign chars_dec = chars_reg - 16'd1;
    assign last      = ({1'b0, column_reg} + 5'd1) >= eff_cols;

    always_comb begin
        phase_next     = phase_reg;
        null_bits_next = null_bits_reg;
        bm_idx_next    = bm_idx_reg;
        column_next    = column_reg;
        fbc_next       = fbc_reg;
        value_next     = value_reg;
        chars_next     = chars_reg;
        do_end         = 1'b0;
        do_mid         = 1'b0;
        item.column_index = column_reg;
        item.kind         = KIND_INT;
        item.is_null      = 1'b0;
        item.value        = 32'd0;

        if (accept) begin
            unique case (ph)
                PH_BITMAP: begin
                    if (!bm_idx) begin
                        null_bits_next = {8'd0, data_byte};
                    end else begin
                        null_bits_next = {data_byte, null_bits_reg[7:0]};
                    end
                    // Up to eight columns fit in one bitmap byte.
                    if (bm_idx || eff_cols <= 5'd8) begin
                        phase_next  = PH_FIELD;
                        bm_idx_next = 1'b0;
                        column_next = 4'd0;
                        fbc_next    = 2'd0;
                        value_next  = 32'd0;
                    end else begin
                        phase_next  = PH_BITMAP;
                        bm_idx_next = 1'b1;
                    end
                end
                PH_CHARS: begin
                    chars_next = chars_dec;
                    item.kind  = KIND_CHAR;
                    item.value = {24'd0, data_byte};
                    if (chars_dec == 16'd0) begin
                        do_end = 1'b1;
                    end else begin
                        do_mid = 1'b1;
                    end
                end
                PH_SKIP: begin
                    chars_next   = chars_dec;
                    item.kind    = KIND_LEN;
                    item.is_null = 1'b1;
                    do_end       = (chars_dec == 16'd0);
                end
                PH_FIELD: begin
                    if (col_type == TYPE_INT) begin
                        value_next   = int_value;
                        item.kind    = KIND_INT;
                        item.is_null = is_null;
                        item.value   = is_null ? 32'd0 : int_value;
                        if (fbc_reg == 2'd3) begin
                            do_end = 1'b1;
                        end else begin
                            fbc_next = fbc_reg + 2'd1;
                        end
                    end else if (col_type == TYPE_VARCHAR) begin
                        if (fbc_reg == 2'd0) begin
                            value_next = {24'd0, data_byte};
                            fbc_next   = 2'd1;
                        end else begin
                            fbc_next     = 2'd0;
                            value_next   = 32'd0;
                            item.kind    = KIND_LEN;
                            item.is_null = is_null;
                            if (len == 16'd0) begin
                                do_end = 1'b1;
                            end else begin
                                chars_next = len;
                                if (is_null) begin
                                    phase_next = PH_SKIP;
                                end else begin
                                    phase_next = PH_CHARS;
                                    item.value = {16'd0, len};
                                    do_mid     = 1'b1;
                                end
                            end
                        end
                    end else begin
                        item.kind    = KIND_BOOL;
                        item.is_null = is_null;
                        item.value   = {31'd0, !is_null && (data_byte != 8'd0)};
                        do_end       = 1'b1;
                    end
                end
                default: phase_next = phase_reg;
            endcase

            // Closing a column moves to the next one or back to the bitmap.
            if (do_end) begin
                fbc_next   = 2'd0;
                value_next = 32'd0;
                chars_next = 16'd0;
                if (last) begin
                    phase_next  = PH_BITMAP;
                    bm_idx_next = 1'b0;
                    column_next = 4'd0;
                end else begin
                    phase_next  = PH_FIELD;
                    column_next = column_reg + 4'd1;
                end
            end
        end

        item.last_of_row = do_end && last;
        push = do_end || do_mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_BITMAP;
            null_bits_reg <= 16'd0;
            bm_idx_reg    <= 1'b0;
            column_reg    <= 4'd0;
            fbc_reg       <= 2'd0;
            value_reg     <= 32'd0;
            chars_reg     <= 16'd0;
        end else begin
            phase_reg     <= phase_next;
            null_bits_reg <= null_bits_next;
            bm_idx_reg    <= bm_idx_next;
            column_reg    <= column_next;
            fbc_reg       <= fbc_next;
            value_reg     <= value_next;
            chars_reg     <= chars_next;
        end
    end

    assign status.phase  = phase_reg;
    assign status.column = column_reg;

endmodule

/* design/rrd_queue.sv */
`timescale 1ns / 1ps
module rrd_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  rrd_pkg::rrd_item_t         push_item,
    output logic                       space,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rrd_pkg::rrd_item_t         m_item,
    output rrd_pkg::rrd_queue_status_t status
);
    import rrd_pkg::*;

    rrd_item_t  entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign space   = (count_reg != 2'(QUEUE_DEPTH));
    assign pop     = m_valid && m_ready;
    assign m_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign status.count = count_reg;

endmodule

/* design/row_record_deserializer_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Row record deserializer: decodes a serialized row stream (null bitmap, then INT, BOOL and
// VARCHAR fields by the configured column types) one byte per item and emits at most one
// result item per byte. A byte is accepted in every cycle while the two-entry result queue
// has room, so the sustained rate is one byte per cycle whenever the result side keeps up;
// each result is registered in the result queue before it reaches the outputs. The byte parser
// in front stalls whenever the result queue behind it is full.
module row_record_deserializer_core #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rrd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_row_start,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [3:0]                 m_column_index,
    output logic [1:0]                 m_kind,
    output logic                       m_is_null,
    output logic [31:0]                m_value,
    output logic                       m_last_of_row
);
    import rrd_pkg::*;

    rrd_cfg_t          cfg;
    rrd_item_t         parse_item;
    rrd_item_t         out_item;
    rrd_parse_status_t parse_status;
    rrd_queue_status_t queue_status;
    logic              parse_push;
    logic              accept;

    assign accept = s_valid && s_ready;

    rrd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rrd_parser #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (s_data_byte),
        .row_start (s_row_start),
        .push      (parse_push),
        .item      (parse_item),
        .status    (parse_status)
    );

    rrd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (parse_push),
        .push_item (parse_item),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (out_item),
        .status    (queue_status)
    );

    assign m_column_index = out_item.column_index;
    assign m_kind         = out_item.kind;
    assign m_is_null      = out_item.is_null;
    assign m_value        = out_item.value;
    assign m_last_of_row  = out_item.last_of_row;

    `ASSERT_NEVER(a_no_overflow,
        parse_push && (queue_status.count == 2'(QUEUE_DEPTH)), "result queue overflow")
    `ASSERT_NEVER(a_push_needs_accept, parse_push && !accept, "result without an accepted item")
    `ASSERT_CLK(a_null_zero,
        parse_push && parse_item.is_null |-> parse_item.value == 32'd0,
        "null result with nonzero value")
    `ASSERT_CLK(a_row_wraps,
        parse_push && parse_item.last_of_row |=>
            (parse_status.phase == PH_BITMAP) && (parse_status.column == 4'd0),
        "row end did not return to bitmap")

endmodule
